@@ sv/btlv_pkg.sv @@
// shared types and constants for the ber-tlv stream parser
`default_nettype none
package btlv_pkg;

	typedef enum logic [5:0] {
		PH_TAG    = 6'b000001,
		PH_TAGEXT = 6'b000010,
		PH_LEN1   = 6'b000100,
		PH_LENX   = 6'b001000,
		PH_VALUE  = 6'b010000,
		PH_DROP   = 6'b100000
	} btlv_phase_t;

	localparam logic [1:0] KIND_ELEMENT = 2'd0;
	localparam logic [1:0] KIND_ERROR   = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_ZERO_EXT  = 3'd1;
	localparam logic [2:0] ERR_LEN_FORM  = 3'd2;
	localparam logic [2:0] ERR_LEN_ZERO  = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

	localparam logic [7:0] PAD_ZERO     = 8'h00;
	localparam logic [7:0] PAD_ONES     = 8'hff;
	localparam logic [4:0] TAG_EXT_MARK = 5'h1f;
	localparam logic [7:0] LEN_LONG_MIN = 8'h80;
	localparam logic [7:0] LEN_LONG_MAX = 8'h84;
	localparam logic [31:0] SHORT_TAG_MAX = 32'd30;

	typedef struct packed {
		btlv_phase_t phase;
		logic [31:0] tag_accum;
		logic [1:0]  class_held;
		logic        constructed_held;
		logic        first_ext_byte;
		logic [31:0] length_accum;
		logic [2:0]  length_bytes_left;
		logic [31:0] value_left;
	} btlv_state_t;

	localparam btlv_state_t STATE_RST = '{
		phase:             PH_TAG,
		tag_accum:         32'd0,
		class_held:        2'd0,
		constructed_held:  1'b0,
		first_ext_byte:    1'b0,
		length_accum:      32'd0,
		length_bytes_left: 3'd0,
		value_left:        32'd0
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tag_number;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [7:0]  short_tag;
		logic [31:0] value_length;
		logic [15:0] value_offset;
		logic        pdu_end;
		logic [2:0]  error_code;
	} btlv_result_t;

endpackage
`default_nettype wire

@@ sv/btlv_step.sv @@
// next-state and result logic for one byte of the ber-tlv parser
`default_nettype none
module btlv_step #(
	parameter int POSITION_BITS = 16
) (
	input  wire btlv_pkg::btlv_state_t  st,
	input  wire [POSITION_BITS-1:0]     pos,
	input  wire [POSITION_BITS-1:0]     vstart,
	input  wire [7:0]                   data_byte,
	input  wire                         last_byte,
	output btlv_pkg::btlv_state_t       st_n,
	output logic [POSITION_BITS-1:0]    pos_n,
	output logic [POSITION_BITS-1:0]    vstart_n,
	output logic                        emit,
	output btlv_pkg::btlv_result_t      res
);

	logic        do_plain;
	logic [1:0]  plain_kind;
	logic [2:0]  plain_code;
	logic        do_elem;
	logic        known;
	logic        trunc_chk;
	logic [31:0] vs_ext;

	always_comb begin
		st_n = st;
		pos_n = pos;
		vstart_n = vstart;
		emit = 1'b0;
		res = '0;
		do_plain = 1'b0;
		plain_kind = btlv_pkg::KIND_ERROR;
		plain_code = btlv_pkg::ERR_NONE;
		do_elem = 1'b0;
		known = 1'b0;
		trunc_chk = 1'b0;
		vs_ext = '0;

		if (st.phase == btlv_pkg::PH_DROP) begin
			if (last_byte) begin
				st_n = btlv_pkg::STATE_RST;
				pos_n = '0;
				vstart_n = '0;
			end
		end else if (&pos) begin
			do_plain = 1'b1;
			plain_code = btlv_pkg::ERR_TOO_LONG;
		end else begin
			pos_n = pos + 1'b1;
			case (st.phase)
				btlv_pkg::PH_TAG: begin
					if (data_byte == btlv_pkg::PAD_ZERO || data_byte == btlv_pkg::PAD_ONES) begin
						if (last_byte) begin
							do_plain = 1'b1;
							plain_kind = btlv_pkg::KIND_END;
						end
					end else begin
						st_n.class_held = data_byte[7:6];
						st_n.constructed_held = data_byte[5];
						if (data_byte[4:0] == btlv_pkg::TAG_EXT_MARK) begin
							st_n.tag_accum = '0;
							st_n.first_ext_byte = 1'b1;
							st_n.phase = btlv_pkg::PH_TAGEXT;
						end else begin
							st_n.tag_accum = {27'd0, data_byte[4:0]};
							st_n.phase = btlv_pkg::PH_LEN1;
						end
						trunc_chk = 1'b1;
					end
				end
				btlv_pkg::PH_TAGEXT: begin
					if (st.first_ext_byte && data_byte[6:0] == 7'd0) begin
						do_plain = 1'b1;
						plain_code = btlv_pkg::ERR_ZERO_EXT;
					end else begin
						st_n.first_ext_byte = 1'b0;
						st_n.tag_accum = {st.tag_accum[24:0], data_byte[6:0]};
						if (!data_byte[7]) begin
							st_n.phase = btlv_pkg::PH_LEN1;
						end
						trunc_chk = 1'b1;
					end
				end
				btlv_pkg::PH_LEN1: begin
					if (!data_byte[7]) begin
						st_n.length_accum = {24'd0, data_byte};
						known = 1'b1;
					end else if (data_byte == btlv_pkg::LEN_LONG_MIN ||
							data_byte > btlv_pkg::LEN_LONG_MAX) begin
						do_plain = 1'b1;
						plain_code = btlv_pkg::ERR_LEN_FORM;
					end else begin
						st_n.length_bytes_left = data_byte[2:0];
						st_n.length_accum = '0;
						st_n.phase = btlv_pkg::PH_LENX;
						trunc_chk = 1'b1;
					end
				end
				btlv_pkg::PH_LENX: begin
					if (st.length_accum == 32'd0 && data_byte == 8'd0) begin
						do_plain = 1'b1;
						plain_code = btlv_pkg::ERR_LEN_ZERO;
					end else begin
						st_n.length_accum = {st.length_accum[23:0], data_byte};
						st_n.length_bytes_left = st.length_bytes_left - 3'd1;
						if (st_n.length_bytes_left == 3'd0) begin
							known = 1'b1;
						end else begin
							trunc_chk = 1'b1;
						end
					end
				end
				btlv_pkg::PH_VALUE: begin
					st_n.value_left = st.value_left - 32'd1;
					if (st_n.value_left == 32'd0) begin
						do_elem = 1'b1;
					end else begin
						trunc_chk = 1'b1;
					end
				end
				default: begin
					st_n = st;
				end
			endcase

			if (known) begin
				vstart_n = pos + 1'b1;
				st_n.value_left = st_n.length_accum;
				if (st_n.length_accum == 32'd0) begin
					do_elem = 1'b1;
				end else begin
					st_n.phase = btlv_pkg::PH_VALUE;
					trunc_chk = 1'b1;
				end
			end

			if (trunc_chk && last_byte) begin
				do_plain = 1'b1;
				plain_code = btlv_pkg::ERR_TRUNCATED;
			end
		end

		if (do_elem) begin
			emit = 1'b1;
			vs_ext = 32'(vstart_n);
			res.kind = btlv_pkg::KIND_ELEMENT;
			res.tag_number = st_n.tag_accum;
			res.tag_class = st_n.class_held;
			res.constructed = st_n.constructed_held;
			if (st_n.tag_accum <= btlv_pkg::SHORT_TAG_MAX) begin
				res.short_tag = {st_n.class_held, st_n.constructed_held, st_n.tag_accum[4:0]};
			end
			res.value_length = st_n.length_accum;
			res.value_offset = vs_ext[15:0];
			res.pdu_end = last_byte;
			res.error_code = btlv_pkg::ERR_NONE;
			if (last_byte) begin
				st_n = btlv_pkg::STATE_RST;
				pos_n = '0;
				vstart_n = '0;
			end else begin
				st_n.phase = btlv_pkg::PH_TAG;
			end
		end else if (do_plain) begin
			emit = 1'b1;
			res.kind = plain_kind;
			res.pdu_end = last_byte;
			res.error_code = plain_code;
			if (last_byte) begin
				st_n = btlv_pkg::STATE_RST;
				pos_n = '0;
				vstart_n = '0;
			end else if (plain_kind == btlv_pkg::KIND_ERROR) begin
				st_n.phase = btlv_pkg::PH_DROP;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/ber_tlv_stream_parser.sv @@
// top level of the ber-tlv stream parser: header state and result register
//
// input channel: one pdu word per accepted cycle (data_byte, last_byte),
// handshake in_valid / in_ready. padding bytes 0x00 and 0xff before a tag
// are skipped. each word gives zero or one result on the output channel
// (out_valid / out_ready): a complete element, an error or a clean end.
// a result appears at the output register in the cycle after the word
// that causes it is accepted. throughput: one word per cycle, set by
// the single pass through the header decode between state and result
// registers. in_ready stays high while the output register is empty or is
// being taken in the same cycle; when the receiver stalls with a result
// held, in_ready drops and the parser waits.
// after the first error the rest of the pdu is dropped silently; every
// last word returns the parser to its reset state.
// reset (arst_n low) empties the output register and clears all header
// state, ready for a new pdu; there is no clearing pass.
`default_nettype none
module ber_tlv_stream_parser #(
	parameter int POSITION_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [7:0]   data_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  kind,
	output logic [31:0] tag_number,
	output logic [1:0]  tag_class,
	output logic        constructed,
	output logic [7:0]  short_tag,
	output logic [31:0] value_length,
	output logic [15:0] value_offset,
	output logic        pdu_end,
	output logic [2:0]  error_code
);

	btlv_pkg::btlv_state_t   st_q;
	btlv_pkg::btlv_state_t   st_n;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_n;
	logic [POSITION_BITS-1:0] vstart_q;
	logic [POSITION_BITS-1:0] vstart_n;
	logic                     emit;
	btlv_pkg::btlv_result_t   res;
	btlv_pkg::btlv_result_t   res_q;
	logic                     out_valid_q;
	logic                     in_accept;

	assign in_ready = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	btlv_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.st        (st_q),
		.pos       (pos_q),
		.vstart    (vstart_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.st_n      (st_n),
		.pos_n     (pos_n),
		.vstart_n  (vstart_n),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= btlv_pkg::STATE_RST;
			pos_q <= '0;
			vstart_q <= '0;
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			st_q <= st_n;
			pos_q <= pos_n;
			vstart_q <= vstart_n;
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = res_q.kind;
	assign tag_number = res_q.tag_number;
	assign tag_class = res_q.tag_class;
	assign constructed = res_q.constructed;
	assign short_tag = res_q.short_tag;
	assign value_length = res_q.value_length;
	assign value_offset = res_q.value_offset;
	assign pdu_end = res_q.pdu_end;
	assign error_code = res_q.error_code;

endmodule
`default_nettype wire

@@ verif/ber_tlv_stream_checker.sv @@
// channel monitor, header decode predictor and result comparison for the ber-tlv parser
module ber_tlv_stream_checker #(
	parameter int POSITION_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire [7:0]   data_byte,
	input  wire         last_byte,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire [1:0]   kind,
	input  wire [31:0]  tag_number,
	input  wire [1:0]   tag_class,
	input  wire         constructed,
	input  wire [7:0]   short_tag,
	input  wire [31:0]  value_length,
	input  wire [15:0]  value_offset,
	input  wire         pdu_end,
	input  wire [2:0]   error_code,
	output int          fails,
	output int          checked,
	output int          pending,
	output int          parsed_words
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] POS_LIMIT = 32'((64'd1 << POSITION_BITS) - 64'd1);

	btlv_pkg::btlv_phase_t  ph;
	logic [31:0]  tag_acc;
	logic [1:0]   cls;
	logic         cons;
	logic         first_ext;
	logic [31:0]  len_acc;
	logic [2:0]   len_left;
	logic [31:0]  val_left;
	logic [31:0]  pos_count;
	logic [31:0]  val_start;

	btlv_pkg::btlv_result_t tlv_reports[$];

	task automatic clear_state();
		ph = btlv_pkg::PH_TAG;
		tag_acc = '0;
		cls = '0;
		cons = 1'b0;
		first_ext = 1'b0;
		len_acc = '0;
		len_left = '0;
		val_left = '0;
		pos_count = '0;
		val_start = '0;
	endtask

	task automatic post_plain(input logic [1:0] k, input logic [2:0] code, input logic l);
		btlv_pkg::btlv_result_t r;
		r = '0;
		r.kind = k;
		r.pdu_end = l;
		r.error_code = code;
		tlv_reports.push_back(r);
		if (l)
			clear_state();
		else if (k == btlv_pkg::KIND_ERROR)
			ph = btlv_pkg::PH_DROP;
	endtask

	task automatic post_element(input logic l);
		btlv_pkg::btlv_result_t r;
		r = '0;
		r.kind = btlv_pkg::KIND_ELEMENT;
		r.tag_number = tag_acc;
		r.tag_class = cls;
		r.constructed = cons;
		r.short_tag = (tag_acc <= btlv_pkg::SHORT_TAG_MAX) ? {cls, cons, tag_acc[4:0]} : 8'h00;
		r.value_length = len_acc;
		r.value_offset = val_start[15:0];
		r.pdu_end = l;
		r.error_code = btlv_pkg::ERR_NONE;
		tlv_reports.push_back(r);
		if (l)
			clear_state();
		else
			ph = btlv_pkg::PH_TAG;
	endtask

	task automatic length_done(input logic [31:0] pos, input logic l);
		val_start = pos + 32'd1;
		val_left = len_acc;
		if (len_acc == 32'd0) begin
			post_element(l);
		end else begin
			ph = btlv_pkg::PH_VALUE;
			if (l)
				post_plain(btlv_pkg::KIND_ERROR, btlv_pkg::ERR_TRUNCATED, 1'b1);
		end
	endtask

	task automatic decode_word(input logic [7:0] b, input logic l);
		logic [31:0] pos;
		logic        done;
		pos = pos_count;
		done = 1'b0;
		if (ph == btlv_pkg::PH_DROP) begin
			if (l)
				clear_state();
		end else if (pos >= POS_LIMIT) begin
			post_plain(btlv_pkg::KIND_ERROR, btlv_pkg::ERR_TOO_LONG, l);
		end else begin
			pos_count = pos + 32'd1;
			case (ph)
				btlv_pkg::PH_TAG: begin
					if (b == btlv_pkg::PAD_ZERO || b == btlv_pkg::PAD_ONES) begin
						done = 1'b1;
						if (l)
							post_plain(btlv_pkg::KIND_END, btlv_pkg::ERR_NONE, 1'b1);
					end else begin
						cls = b[7:6];
						cons = b[5];
						if (b[4:0] == btlv_pkg::TAG_EXT_MARK) begin
							tag_acc = '0;
							first_ext = 1'b1;
							ph = btlv_pkg::PH_TAGEXT;
						end else begin
							tag_acc = {27'd0, b[4:0]};
							ph = btlv_pkg::PH_LEN1;
						end
					end
				end
				btlv_pkg::PH_TAGEXT: begin
					if (first_ext && b[6:0] == 7'd0) begin
						post_plain(btlv_pkg::KIND_ERROR, btlv_pkg::ERR_ZERO_EXT, l);
						done = 1'b1;
					end else begin
						first_ext = 1'b0;
						tag_acc = {tag_acc[24:0], b[6:0]};
						if (!b[7])
							ph = btlv_pkg::PH_LEN1;
					end
				end
				btlv_pkg::PH_LEN1: begin
					if (b < btlv_pkg::LEN_LONG_MIN) begin
						len_acc = {24'd0, b};
						length_done(pos, l);
						done = 1'b1;
					end else if (b == btlv_pkg::LEN_LONG_MIN || b > btlv_pkg::LEN_LONG_MAX) begin
						post_plain(btlv_pkg::KIND_ERROR, btlv_pkg::ERR_LEN_FORM, l);
						done = 1'b1;
					end else begin
						len_left = b[2:0];
						len_acc = '0;
						ph = btlv_pkg::PH_LENX;
					end
				end
				btlv_pkg::PH_LENX: begin
					if (len_acc == 32'd0 && b == 8'h00) begin
						post_plain(btlv_pkg::KIND_ERROR, btlv_pkg::ERR_LEN_ZERO, l);
						done = 1'b1;
					end else begin
						len_acc = {len_acc[23:0], b};
						len_left = len_left - 3'd1;
						if (len_left == 3'd0) begin
							length_done(pos, l);
							done = 1'b1;
						end
					end
				end
				default: begin
					val_left = val_left - 32'd1;
					if (val_left == 32'd0) begin
						post_element(l);
						done = 1'b1;
					end
				end
			endcase
			if (!done && l)
				post_plain(btlv_pkg::KIND_ERROR, btlv_pkg::ERR_TRUNCATED, 1'b1);
		end
	endtask

	task automatic diff_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_report();
		btlv_pkg::btlv_result_t want;
		if (tlv_reports.size() == 0) begin
			fails++;
			$display("%0t: result kind %0h expected none actual one", $time, kind);
		end else begin
			want = tlv_reports.pop_front();
			checked++;
			diff_field("kind", 32'(want.kind), 32'(kind));
			diff_field("tag_number", want.tag_number, tag_number);
			diff_field("tag_class", 32'(want.tag_class), 32'(tag_class));
			diff_field("constructed", 32'(want.constructed), 32'(constructed));
			diff_field("short_tag", 32'(want.short_tag), 32'(short_tag));
			diff_field("value_length", want.value_length, value_length);
			diff_field("value_offset", 32'(want.value_offset), 32'(value_offset));
			diff_field("pdu_end", 32'(want.pdu_end), 32'(pdu_end));
			diff_field("error_code", 32'(want.error_code), 32'(error_code));
		end
	endtask

	initial begin
		clear_state();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_report();
			if (in_valid && in_ready) begin
				if (ph != btlv_pkg::PH_DROP)
					parsed_words++;
				decode_word(data_byte, last_byte);
			end
			pending = tlv_reports.size();
		end
	end

endmodule

@@ verif/ber_tlv_stream_parser_tb.sv @@
// testbench top for the ber-tlv stream parser: clock, reset, pdu stimulus and verdict
module ber_tlv_stream_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] tag_number;
	logic [1:0]  tag_class;
	logic        constructed;
	logic [7:0]  short_tag;
	logic [31:0] value_length;
	logic [15:0] value_offset;
	logic        pdu_end;
	logic [2:0]  error_code;

	int fails;
	int checked;
	int pending;
	int parsed_words;

	bit          calm = 1'b0;
	logic [7:0]  pdu[$];
	int          words_sent = 0;
	int          pdus_sent = 0;

	ber_tlv_stream_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.tag_number(tag_number),
		.tag_class(tag_class),
		.constructed(constructed),
		.short_tag(short_tag),
		.value_length(value_length),
		.value_offset(value_offset),
		.pdu_end(pdu_end),
		.error_code(error_code)
	);

	ber_tlv_stream_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.tag_number(tag_number),
		.tag_class(tag_class),
		.constructed(constructed),
		.short_tag(short_tag),
		.value_length(value_length),
		.value_offset(value_offset),
		.pdu_end(pdu_end),
		.error_code(error_code),
		.fails(fails),
		.checked(checked),
		.pending(pending),
		.parsed_words(parsed_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// receiver stalls
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	task automatic push_word(input logic [7:0] b, input logic l);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_pdu();
		foreach (pdu[i])
			push_word(pdu[i], i == pdu.size() - 1);
		pdus_sent++;
	endtask

	task automatic add_element(output bit stop);
		logic [7:0] b;
		int         n;
		int         vlen;
		int         r;
		stop = 1'b0;
		vlen = 0;
		if ($urandom_range(0, 3) != 0) begin
			b = 8'($urandom);
			while (b == btlv_pkg::PAD_ZERO || b[4:0] == btlv_pkg::TAG_EXT_MARK)
				b = 8'($urandom);
			pdu.push_back(b);
		end else begin
			b = 8'($urandom);
			b[4:0] = btlv_pkg::TAG_EXT_MARK;
			pdu.push_back(b);
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom);
				b[7] = (i != n - 1);
				if (i == 0 && $urandom_range(0, 19) == 0)
					b[6:0] = 7'd0;
				else if (i == 0 && b[6:0] == 7'd0)
					b[0] = 1'b1;
				pdu.push_back(b);
			end
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			vlen = $urandom_range(0, 12);
			pdu.push_back(vlen[7:0]);
		end else if (r < 80) begin
			vlen = $urandom_range(13, 127);
			pdu.push_back(vlen[7:0]);
		end else if (r < 88) begin
			vlen = $urandom_range(0, 40);
			pdu.push_back(8'h81);
			pdu.push_back(vlen[7:0]);
		end else if (r < 92) begin
			vlen = $urandom_range(256, 300);
			pdu.push_back(8'h82);
			pdu.push_back(vlen[15:8]);
			pdu.push_back(vlen[7:0]);
		end else if (r < 96) begin
			if ($urandom_range(0, 1) != 0)
				pdu.push_back(btlv_pkg::LEN_LONG_MIN);
			else
				pdu.push_back(8'($urandom_range(8'h85, 8'hff)));
			stop = 1'b1;
		end else begin
			n = $urandom_range(3, 4);
			pdu.push_back(btlv_pkg::LEN_LONG_MIN + 8'(n));
			pdu.push_back(8'($urandom_range(1, 255)));
			repeat (n - 1) pdu.push_back(8'($urandom));
			vlen = $urandom_range(0, 5);
			stop = 1'b1;
		end
		repeat (vlen) pdu.push_back(8'($urandom));
	endtask

	task automatic build_pdu();
		int n;
		int cut;
		bit stop;
		pdu.delete();
		stop = 1'b0;
		if ($urandom_range(0, 99) < 20) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				case ($urandom_range(0, 17))
					0: pdu.push_back(btlv_pkg::PAD_ZERO);
					1: pdu.push_back(btlv_pkg::PAD_ONES);
					2: pdu.push_back(btlv_pkg::LEN_LONG_MIN);
					3: pdu.push_back(btlv_pkg::LEN_LONG_MAX);
					4: pdu.push_back(8'h85);
					5: pdu.push_back(8'h9f);
					6: pdu.push_back(8'h7f);
					7: pdu.push_back(8'h81);
					default: pdu.push_back(8'($urandom));
				endcase
			end
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n && !stop; i++) begin
				if ($urandom_range(0, 9) < 3)
					repeat ($urandom_range(1, 2))
						pdu.push_back($urandom_range(0, 1) != 0 ?
							btlv_pkg::PAD_ONES : btlv_pkg::PAD_ZERO);
				add_element(stop);
			end
			if (!stop && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					pdu.push_back($urandom_range(0, 1) != 0 ?
						btlv_pkg::PAD_ONES : btlv_pkg::PAD_ZERO);
			if ($urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, pdu.size());
				while (pdu.size() > cut)
					void'(pdu.pop_back());
			end
		end
	endtask

	initial begin
		int start;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// element closed by the last word, after padding
		pdu = '{8'h00, 8'hff, 8'h5a, 8'h01, 8'h33};
		send_pdu();
		// padding alone
		pdu = '{8'hff};
		send_pdu();
		// extended tag with empty first byte, rest dropped
		pdu = '{8'h9f, 8'h80, 8'h12};
		send_pdu();
		// reserved length form on the last word
		pdu = '{8'h01, 8'h80};
		send_pdu();
		// leading zero in long length
		pdu = '{8'h02, 8'h81, 8'h00};
		send_pdu();
		// three-byte tag, empty value, trailing padding
		pdu = '{8'h3f, 8'h81, 8'h05, 8'h00, 8'h00};
		send_pdu();
		// cut inside the long length
		pdu = '{8'hc4, 8'h82, 8'h01};
		send_pdu();

		start = parsed_words;
		while (parsed_words - start < 700) begin
			calm = ($urandom_range(0, 9) == 0);
			build_pdu();
			send_pdu();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("sent %0d words in %0d pdus: padding, long tags and lengths, cut pdus", words_sent,
			pdus_sent);
		$display("compared %0d results, %0d mismatches", checked, fails);
		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
